// File: sv/hte_pkg.sv
// Shared types and constants for the handle table engine.
`default_nettype none

package hte_pkg;

    localparam int SLOTS          = 16;
    localparam int SLOT_BITS      = $clog2(SLOTS);
    localparam int CAP_BITS       = SLOT_BITS + 1;
    localparam int ID_BITS        = 16;
    localparam int ID_CNT_BITS    = $clog2(ID_BITS);
    localparam int TAG_BITS       = 32;
    localparam int MODE_BITS      = 3;
    localparam int MIN_CAP        = 2;
    localparam int CAPACITY_RESET = 16;
    // Queue depth must be a power of two so the pointers wrap by themselves.
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

    localparam logic [MODE_BITS-1:0] MODE_ATTACH    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_UNREG     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_REGISTER  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_LOOK_ID   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_LOOK_PAIR = 3'd4;

    typedef enum logic [2:0] {
        OP_ATTACH,
        OP_UNREG,
        OP_REGISTER,
        OP_LOOK_ID,
        OP_LOOK_PAIR,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [ID_BITS-1:0]   handle_id;
        logic [TAG_BITS-1:0]  handler_tag;
        logic [TAG_BITS-1:0]  object_tag;
    } t_cmd;

    typedef struct packed {
        logic                ok;
        logic [ID_BITS-1:0]  result_id;
        logic [TAG_BITS-1:0] found_handler;
        logic [TAG_BITS-1:0] found_object;
    } t_rsp;

    typedef struct packed {
        t_op                  op;
        logic [ID_BITS-1:0]   id;
        logic [TAG_BITS-1:0]  h;
        logic [TAG_BITS-1:0]  o;
        logic [SLOT_BITS-1:0] home;
        logic [CAP_BITS-1:0]  cap;
    } t_item;

endpackage

`default_nettype wire

// File: sv/hte_front.sv
// Front end: accepts commands, decodes the mode and computes the home slot.
`default_nettype none

module hte_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire hte_pkg::t_cmd                i_cmd,
    input  wire logic                         i_cfg_we,
    input  wire logic [hte_pkg::CAP_BITS-1:0] i_cfg_wdata,
    input  wire logic                         i_full,
    output logic                              o_busy,
    output logic                              o_push,
    output hte_pkg::t_item                    o_item
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH
    } t_state;

    t_state                               r_state;
    logic [hte_pkg::CAP_BITS-1:0]         r_capacity;
    hte_pkg::t_item                       r_item;
    logic [hte_pkg::SLOT_BITS-1:0]        r_rem;
    logic [hte_pkg::ID_CNT_BITS-1:0]      r_bit;

    logic [hte_pkg::CAP_BITS-1:0]         w_eff_cap;
    logic [hte_pkg::CAP_BITS-1:0]         w_shift;
    logic [hte_pkg::SLOT_BITS-1:0]        n_rem;
    hte_pkg::t_op                         w_op;

    always_comb begin
        if (r_capacity < hte_pkg::CAP_BITS'(hte_pkg::MIN_CAP)) begin
            w_eff_cap = hte_pkg::CAP_BITS'(hte_pkg::MIN_CAP);
        end else if (r_capacity > hte_pkg::CAP_BITS'(hte_pkg::SLOTS)) begin
            w_eff_cap = hte_pkg::CAP_BITS'(hte_pkg::SLOTS);
        end else begin
            w_eff_cap = r_capacity;
        end
    end

    always_comb begin
        unique case (i_cmd.mode)
            hte_pkg::MODE_ATTACH:    w_op = hte_pkg::OP_ATTACH;
            hte_pkg::MODE_UNREG:     w_op = hte_pkg::OP_UNREG;
            hte_pkg::MODE_REGISTER:  w_op = hte_pkg::OP_REGISTER;
            hte_pkg::MODE_LOOK_ID:   w_op = hte_pkg::OP_LOOK_ID;
            hte_pkg::MODE_LOOK_PAIR: w_op = hte_pkg::OP_LOOK_PAIR;
            default:                 w_op = hte_pkg::OP_NONE;
        endcase
    end

    // Restoring remainder, one id bit per cycle from the top. The remainder
    // stays below the capacity, so it always fits a slot index.
    always_comb begin
        w_shift = {r_rem, r_item.id[r_bit]};
        if (w_shift >= r_item.cap) begin
            n_rem = hte_pkg::SLOT_BITS'(w_shift - r_item.cap);
        end else begin
            n_rem = hte_pkg::SLOT_BITS'(w_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_capacity <= hte_pkg::CAP_BITS'(hte_pkg::CAPACITY_RESET);
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_item.op   <= w_op;
                        r_item.id   <= i_cmd.handle_id;
                        r_item.h    <= i_cmd.handler_tag;
                        r_item.o    <= i_cmd.object_tag;
                        r_item.home <= '0;
                        r_item.cap  <= w_eff_cap;
                        r_rem       <= '0;
                        r_bit       <= hte_pkg::ID_CNT_BITS'(hte_pkg::ID_BITS - 1);
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    if (r_bit == '0) begin
                        r_item.home <= n_rem;
                        r_state     <= ST_PUSH;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                ST_PUSH: begin
                    if (!i_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_push = (r_state == ST_PUSH) && !i_full;
    assign o_item = r_item;

endmodule

`default_nettype wire

// File: sv/hte_queue.sv
// Small FIFO of decoded commands between the front end and the table engine.
`default_nettype none

module hte_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hte_pkg::t_item i_item,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output hte_pkg::t_item      o_item
);

    hte_pkg::t_item                r_mem [hte_pkg::QUEUE_DEPTH];
    logic [hte_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [hte_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [hte_pkg::QPTR_BITS:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == (hte_pkg::QPTR_BITS + 1)'(hte_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// File: sv/hte_back.sv
// Table engine: holds the slot table and carries out one command at a time.
`default_nettype none

module hte_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire hte_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_strobe,
    output hte_pkg::t_rsp       o_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOME,
        ST_SCAN
    } t_state;

    // Slot table; an entry whose valid bit is clear reads as empty.
    logic [hte_pkg::ID_BITS-1:0]   r_slot_id [hte_pkg::SLOTS];
    logic [hte_pkg::TAG_BITS-1:0]  r_slot_h  [hte_pkg::SLOTS];
    logic [hte_pkg::TAG_BITS-1:0]  r_slot_o  [hte_pkg::SLOTS];
    logic [hte_pkg::SLOTS-1:0]     r_valid;

    logic [hte_pkg::ID_BITS-1:0]   r_rd_id;
    logic [hte_pkg::TAG_BITS-1:0]  r_rd_h;
    logic [hte_pkg::TAG_BITS-1:0]  r_rd_o;
    logic                          r_rd_vld;

    t_state                        r_state;
    hte_pkg::t_item                r_cur;
    logic [hte_pkg::SLOT_BITS-1:0] r_idx;
    logic                          r_have_empty;
    logic [hte_pkg::SLOT_BITS-1:0] r_empty;
    logic                          r_strobe;
    hte_pkg::t_rsp                 r_rsp;

    t_state                        n_state;
    hte_pkg::t_item                n_cur;
    logic [hte_pkg::SLOT_BITS-1:0] n_idx;
    logic                          n_have_empty;
    logic [hte_pkg::SLOT_BITS-1:0] n_empty;
    logic                          n_strobe;
    hte_pkg::t_rsp                 n_rsp;

    logic [hte_pkg::SLOT_BITS-1:0] w_rd_addr;
    logic                          w_wr_en;
    logic [hte_pkg::SLOT_BITS-1:0] w_wr_addr;
    logic                          w_wr_valid;
    logic [hte_pkg::ID_BITS-1:0]   w_wr_id;

    logic [hte_pkg::ID_BITS-1:0]   w_id;
    logic [hte_pkg::TAG_BITS-1:0]  w_h;
    logic [hte_pkg::TAG_BITS-1:0]  w_o;
    logic                          w_id_hit;
    logic                          w_pair_hit;
    logic                          w_last;
    logic                          w_id_op;
    logic                          w_trivial_fail;
    logic                          w_use_home;
    logic [hte_pkg::SLOT_BITS-1:0] w_new_slot;

    always_comb begin
        w_id       = r_rd_vld ? r_rd_id : '0;
        w_h        = r_rd_vld ? r_rd_h : '0;
        w_o        = r_rd_vld ? r_rd_o : '0;
        w_id_hit   = (w_id == r_cur.id);
        w_pair_hit = (w_id != '0) && (w_h == r_cur.h) && (w_o == r_cur.o);
        w_last     = ({1'b0, r_idx} == r_cur.cap - 1'b1);
        w_new_slot = r_have_empty ? r_empty : r_idx;

        w_id_op = (i_item.op == hte_pkg::OP_ATTACH) || (i_item.op == hte_pkg::OP_UNREG) ||
                  (i_item.op == hte_pkg::OP_LOOK_ID);
        w_trivial_fail = (i_item.op == hte_pkg::OP_NONE) ||
                         (w_id_op && (i_item.id == '0)) ||
                         ((i_item.op == hte_pkg::OP_ATTACH) && (i_item.home == '0));
        w_use_home = w_id_op && (i_item.home != '0);
    end

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_have_empty = r_have_empty;
        n_empty      = r_empty;
        n_strobe     = 1'b0;
        n_rsp        = r_rsp;
        o_pop        = 1'b0;
        w_rd_addr    = r_idx + 1'b1;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_idx;
        w_wr_valid   = 1'b0;
        w_wr_id      = r_cur.id;

        unique case (r_state)
            ST_IDLE: begin
                w_rd_addr = w_use_home ? i_item.home : hte_pkg::SLOT_BITS'(1);
                if (!i_empty) begin
                    o_pop        = 1'b1;
                    n_cur        = i_item;
                    n_idx        = hte_pkg::SLOT_BITS'(1);
                    n_have_empty = 1'b0;
                    priority if (w_trivial_fail) begin
                        n_strobe = 1'b1;
                        n_rsp    = '0;
                    end else if (w_use_home) begin
                        n_state = ST_HOME;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_HOME: begin
                w_rd_addr = hte_pkg::SLOT_BITS'(1);
                n_idx     = hte_pkg::SLOT_BITS'(1);
                w_wr_addr = r_cur.home;
                n_rsp     = '0;
                if (r_cur.op == hte_pkg::OP_ATTACH) begin
                    // Attach takes the home slot when it is free or already ours.
                    if (w_id_hit || (w_id == '0)) begin
                        w_wr_en         = 1'b1;
                        w_wr_valid      = 1'b1;
                        n_rsp.ok        = 1'b1;
                        n_rsp.result_id = r_cur.id;
                    end
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else if (w_id_hit) begin
                    n_rsp.ok        = 1'b1;
                    n_rsp.result_id = r_cur.id;
                    if (r_cur.op == hte_pkg::OP_UNREG) begin
                        w_wr_en = 1'b1;
                    end else begin
                        n_rsp.found_handler = w_h;
                        n_rsp.found_object  = w_o;
                    end
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_rsp = '0;
                if (((r_cur.op == hte_pkg::OP_UNREG || r_cur.op == hte_pkg::OP_LOOK_ID) &&
                     w_id_hit) ||
                    ((r_cur.op == hte_pkg::OP_REGISTER || r_cur.op == hte_pkg::OP_LOOK_PAIR) &&
                     w_pair_hit)) begin
                    n_rsp.ok        = 1'b1;
                    n_rsp.result_id = w_id;
                    unique case (r_cur.op)
                        hte_pkg::OP_UNREG: begin
                            w_wr_en = 1'b1;
                        end
                        hte_pkg::OP_LOOK_ID: begin
                            n_rsp.found_handler = w_h;
                            n_rsp.found_object  = w_o;
                        end
                        default: begin
                        end
                    endcase
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else if (w_last) begin
                    // No pair match anywhere: register falls back to the first free slot.
                    if ((r_cur.op == hte_pkg::OP_REGISTER) && (r_have_empty || (w_id == '0))) begin
                        w_wr_en         = 1'b1;
                        w_wr_valid      = 1'b1;
                        w_wr_addr       = w_new_slot;
                        w_wr_id         = hte_pkg::ID_BITS'(w_new_slot);
                        n_rsp.ok        = 1'b1;
                        n_rsp.result_id = hte_pkg::ID_BITS'(w_new_slot);
                    end
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    if (!r_have_empty && (w_id == '0)) begin
                        n_have_empty = 1'b1;
                        n_empty      = r_idx;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_slot_id[w_wr_addr] <= w_wr_id;
            r_slot_h[w_wr_addr]  <= r_cur.h;
            r_slot_o[w_wr_addr]  <= r_cur.o;
        end
        r_rd_id  <= r_slot_id[w_rd_addr];
        r_rd_h   <= r_slot_h[w_rd_addr];
        r_rd_o   <= r_slot_o[w_rd_addr];
        r_rd_vld <= r_valid[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_wr_en) begin
            r_valid[w_wr_addr] <= w_wr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_strobe     <= n_strobe;
            r_cur        <= n_cur;
            r_idx        <= n_idx;
            r_have_empty <= n_have_empty;
            r_empty      <= n_empty;
            r_rsp        <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

`default_nettype wire

// File: sv/handle_table_engine.sv
// Top level of the handle table engine: front end, command queue and table engine.
//
//   channel   handshake           payload
//   command   start / busy        i_cmd (hte_pkg::t_cmd)
//   result    o_strobe            o_rsp (hte_pkg::t_rsp)
//   config    i_cfg_we            i_cfg_wdata (capacity)
//
// Busy stays high after a command is taken, through the bit-serial id modulo capacity
// and until the item is handed to the queue, which waits while the queue is full; the
// front end takes the next command once the last one is queued. The table engine dequeues
// a command, checks the home slot for id modes with a nonzero home and, unless that settles
// it, scans slots 1 to capacity-1; the result beat is registered. After reset the table is
// empty at once. The receiver cannot stall, so the queue only absorbs engine time.
`default_nettype none

module handle_table_engine (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire hte_pkg::t_cmd                i_cmd,
    input  wire logic                         i_cfg_we,
    input  wire logic [hte_pkg::CAP_BITS-1:0] i_cfg_wdata,
    output logic                              o_strobe,
    output hte_pkg::t_rsp                     o_rsp
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    hte_pkg::t_item w_front_item;
    hte_pkg::t_item w_back_item;

    hte_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (w_full),
        .o_busy      (busy),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    hte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_back_item)
    );

    hte_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_item   (w_back_item),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the handle table engine: directed table, then random phases.
`timescale 1ns / 1ps

module tb;

    localparam int PERIOD          = 8;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 84;
    localparam int MAX_GAP         = 24;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [hte_pkg::MODE_BITS-1:0] MODE_SPARE_LO = hte_pkg::MODE_LOOK_PAIR + 1'b1;
    localparam logic [hte_pkg::MODE_BITS-1:0] MODE_SPARE_HI = '1;

    // Capacity per random phase; out-of-range writes exercise the clamping.
    localparam int PHASE_CAP [PHASES] = '{16, 0, 1, 2, 3, 31, 17, 5, 8, 4, 7, 16};

    typedef struct packed {
        hte_pkg::t_cmd cmd;
        logic          fixed;
        hte_pkg::t_rsp rsp;
    } t_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    hte_pkg::t_cmd                i_cmd;
    logic                         i_cfg_we;
    logic [hte_pkg::CAP_BITS-1:0] i_cfg_wdata;
    logic                         o_strobe;
    hte_pkg::t_rsp                o_rsp;

    // A directed row may carry a hand-written result that replaces the prediction.
    logic          fixed_valid;
    hte_pkg::t_rsp fixed_rsp;

    // Table shadow kept in step with every accepted command.
    logic [hte_pkg::CAP_BITS-1:0] cap_reg;
    logic [hte_pkg::ID_BITS-1:0]  tbl_id      [hte_pkg::SLOTS];
    logic [hte_pkg::TAG_BITS-1:0] tbl_handler [hte_pkg::SLOTS];
    logic [hte_pkg::TAG_BITS-1:0] tbl_object  [hte_pkg::SLOTS];

    hte_pkg::t_rsp rsp_due [$];
    int   n_mismatch = 0;
    int   n_checked  = 0;
    int   n_sent     = 0;
    int   cycles     = 0;
    int   idle_pct   = 0;

    handle_table_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    function automatic int usable_slots();
        int c;
        c = int'(cap_reg);
        if (c < hte_pkg::MIN_CAP) c = hte_pkg::MIN_CAP;
        if (c > hte_pkg::SLOTS) c = hte_pkg::SLOTS;
        return c;
    endfunction

    // Home slot first, then a scan of every slot in use; zero means not present.
    function automatic int slot_of_id(logic [hte_pkg::ID_BITS-1:0] id, int cap);
        int home;
        home = int'(id) % cap;
        if (home != 0 && tbl_id[home] == id) return home;
        for (int i = 1; i < cap; i++)
            if (tbl_id[i] == id) return i;
        return 0;
    endfunction

    function automatic int slot_of_pair(logic [hte_pkg::TAG_BITS-1:0] h,
                                        logic [hte_pkg::TAG_BITS-1:0] o, int cap);
        for (int i = 1; i < cap; i++)
            if (tbl_id[i] != '0 && tbl_handler[i] == h && tbl_object[i] == o) return i;
        return 0;
    endfunction

    function automatic hte_pkg::t_rsp apply_cmd(hte_pkg::t_cmd c);
        hte_pkg::t_rsp r;
        int   cap;
        int   s;
        r   = '0;
        cap = usable_slots();
        case (c.mode)
            hte_pkg::MODE_ATTACH: begin
                s = int'(c.handle_id) % cap;
                if (c.handle_id != '0 && s != 0 &&
                    (tbl_id[s] == c.handle_id || tbl_id[s] == '0)) begin
                    tbl_id[s]      = c.handle_id;
                    tbl_handler[s] = c.handler_tag;
                    tbl_object[s]  = c.object_tag;
                    r.ok           = 1'b1;
                    r.result_id    = c.handle_id;
                end
            end
            hte_pkg::MODE_UNREG: begin
                s = (c.handle_id != '0) ? slot_of_id(c.handle_id, cap) : 0;
                if (s != 0) begin
                    tbl_id[s]      = '0;
                    tbl_handler[s] = '0;
                    tbl_object[s]  = '0;
                    r.ok           = 1'b1;
                    r.result_id    = c.handle_id;
                end
            end
            hte_pkg::MODE_REGISTER: begin
                s = slot_of_pair(c.handler_tag, c.object_tag, cap);
                if (s != 0) begin
                    r.ok        = 1'b1;
                    r.result_id = tbl_id[s];
                end else begin
                    // The slot number itself becomes the new id.
                    for (int i = cap - 1; i >= 1; i--)
                        if (tbl_id[i] == '0) s = i;
                    if (s != 0) begin
                        tbl_id[s]      = hte_pkg::ID_BITS'(s);
                        tbl_handler[s] = c.handler_tag;
                        tbl_object[s]  = c.object_tag;
                        r.ok           = 1'b1;
                        r.result_id    = hte_pkg::ID_BITS'(s);
                    end
                end
            end
            hte_pkg::MODE_LOOK_ID: begin
                s = (c.handle_id != '0) ? slot_of_id(c.handle_id, cap) : 0;
                if (s != 0) begin
                    r.ok            = 1'b1;
                    r.result_id     = tbl_id[s];
                    r.found_handler = tbl_handler[s];
                    r.found_object  = tbl_object[s];
                end
            end
            hte_pkg::MODE_LOOK_PAIR: begin
                s = slot_of_pair(c.handler_tag, c.object_tag, cap);
                if (s != 0) begin
                    r.ok        = 1'b1;
                    r.result_id = tbl_id[s];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Result check first, so a stray result can never claim the expectation
    // queued at the same edge.
    always @(posedge i_clk) begin : monitor
        hte_pkg::t_rsp want;
        hte_pkg::t_rsp predicted;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles,
                     rsp_due.size());
            $display("Mismatches found");
            $finish;
        end
        if (i_rst_n) begin
            if (o_strobe) begin
                if (rsp_due.size() == 0) begin
                    if (n_mismatch < REPORT_LIMIT)
                        $display("%0t: unexpected result beat %p", $realtime, o_rsp);
                    n_mismatch++;
                end else begin
                    want = rsp_due.pop_front();
                    n_checked++;
                    if (o_rsp.ok !== want.ok || o_rsp.result_id !== want.result_id ||
                        o_rsp.found_handler !== want.found_handler ||
                        o_rsp.found_object !== want.found_object) begin
                        if (n_mismatch < REPORT_LIMIT) begin
                            $display("%0t: result %0d differs", $realtime, n_checked);
                            $display("  expected ok=%0b id=%h h=%h o=%h", want.ok,
                                     want.result_id, want.found_handler, want.found_object);
                            $display("  got      ok=%0b id=%h h=%h o=%h", o_rsp.ok,
                                     o_rsp.result_id, o_rsp.found_handler,
                                     o_rsp.found_object);
                        end
                        n_mismatch++;
                    end
                end
            end
            if (start && !busy) begin
                predicted = apply_cmd(i_cmd);
                rsp_due.push_back(fixed_valid ? fixed_rsp : predicted);
                n_sent++;
            end
            if (i_cfg_we) cap_reg = i_cfg_wdata;
        end
    end

    function automatic t_row chk_row(logic [hte_pkg::MODE_BITS-1:0] m,
                                     logic [hte_pkg::ID_BITS-1:0] id,
                                     logic [hte_pkg::TAG_BITS-1:0] h,
                                     logic [hte_pkg::TAG_BITS-1:0] o,
                                     logic ok, logic [hte_pkg::ID_BITS-1:0] rid,
                                     logic [hte_pkg::TAG_BITS-1:0] fh,
                                     logic [hte_pkg::TAG_BITS-1:0] fo);
        return '{cmd: '{mode: m, handle_id: id, handler_tag: h, object_tag: o}, fixed: 1'b1,
                 rsp: '{ok: ok, result_id: rid, found_handler: fh, found_object: fo}};
    endfunction

    function automatic t_row open_row(logic [hte_pkg::MODE_BITS-1:0] m,
                                      logic [hte_pkg::ID_BITS-1:0] id,
                                      logic [hte_pkg::TAG_BITS-1:0] h,
                                      logic [hte_pkg::TAG_BITS-1:0] o);
        return '{cmd: '{mode: m, handle_id: id, handler_tag: h, object_tag: o}, fixed: 1'b0,
                 rsp: '0};
    endfunction

    // Many ids and tag pairs are ones that already live in the table, so attach collisions,
    // pair reuse, hits by id and full tables all come up often.
    function automatic hte_pkg::t_cmd random_cmd();
        hte_pkg::t_cmd c;
        int   r;
        int   k;
        int   p;
        r = $urandom_range(99);
        if (r < 25)      c.mode = hte_pkg::MODE_ATTACH;
        else if (r < 45) c.mode = hte_pkg::MODE_REGISTER;
        else if (r < 60) c.mode = hte_pkg::MODE_UNREG;
        else if (r < 80) c.mode = hte_pkg::MODE_LOOK_ID;
        else if (r < 95) c.mode = hte_pkg::MODE_LOOK_PAIR;
        else c.mode = hte_pkg::MODE_BITS'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        k = $urandom_range(1, hte_pkg::SLOTS - 1);
        r = $urandom_range(99);
        if (r < 50 && tbl_id[k] != '0) c.handle_id = tbl_id[k];
        else if (r < 70)               c.handle_id = hte_pkg::ID_BITS'($urandom_range(0, 40));
        else if (r < 75)               c.handle_id = r[0] ? '1 : '0;
        else                           c.handle_id = hte_pkg::ID_BITS'($urandom());
        r = $urandom_range(99);
        if (r < 35) begin
            p             = $urandom_range(0, 3);
            c.handler_tag = hte_pkg::TAG_BITS'(p) * 32'h0101_0101;
            c.object_tag  = hte_pkg::TAG_BITS'(p) * 32'h0001_0001;
        end else if (r < 60 && tbl_id[k] != '0) begin
            c.handler_tag = tbl_handler[k];
            c.object_tag  = tbl_object[k];
        end else begin
            c.handler_tag = $urandom();
            c.object_tag  = $urandom();
        end
        return c;
    endfunction

    // Presents one beat and holds it until the handshake; start stays high
    // unless the sender decides to pause.
    task automatic issue_cmd(input hte_pkg::t_cmd c, input logic fixed,
                             input hte_pkg::t_rsp want);
        start       <= 1'b1;
        i_cmd       <= c;
        fixed_valid <= fixed;
        fixed_rsp   <= want;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
    endtask

    // Waits on the clock first, so a command taken at the current edge is already counted
    // as outstanding before the idle check.
    task automatic set_capacity(input int value);
        start <= 1'b0;
        @(posedge i_clk);
        while (rsp_due.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= hte_pkg::CAP_BITS'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        t_row rows [$];
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        fixed_valid <= 1'b0;
        fixed_rsp   <= '0;
        cap_reg = hte_pkg::CAP_BITS'(hte_pkg::CAPACITY_RESET);
        for (int i = 0; i < hte_pkg::SLOTS; i++) begin
            tbl_id[i]      = '0;
            tbl_handler[i] = '0;
            tbl_object[i]  = '0;
        end

        // Capacity is 16 after reset, so the home slot is the low nibble of the id.
        rows = '{
            chk_row(hte_pkg::MODE_LOOK_ID, 16'd5, '0, '0, 1'b0, '0, '0, '0),
            chk_row(hte_pkg::MODE_ATTACH, 16'd0, 32'd1, 32'd1, 1'b0, '0, '0, '0),
            chk_row(hte_pkg::MODE_ATTACH, 16'h0010, 32'd1, 32'd1, 1'b0, '0, '0, '0),
            chk_row(hte_pkg::MODE_ATTACH, 16'hFFFF, '1, '1, 1'b1, 16'hFFFF, '0, '0),
            chk_row(hte_pkg::MODE_LOOK_ID, 16'hFFFF, '0, '0, 1'b1, 16'hFFFF, '1, '1),
            chk_row(hte_pkg::MODE_ATTACH, 16'h001F, 32'd2, 32'd2, 1'b0, '0, '0, '0),
            open_row(hte_pkg::MODE_ATTACH, 16'hFFFF, 32'h1234_5678, 32'h9ABC_DEF0),
            chk_row(hte_pkg::MODE_REGISTER, '0, '0, '0, 1'b1, 16'd1, '0, '0),
            chk_row(hte_pkg::MODE_REGISTER, '0, '0, '0, 1'b1, 16'd1, '0, '0),
            chk_row(hte_pkg::MODE_LOOK_PAIR, '0, '0, '0, 1'b1, 16'd1, '0, '0),
            open_row(hte_pkg::MODE_LOOK_PAIR, '0, 32'h1234_5678, 32'h9ABC_DEF0),
            open_row(hte_pkg::MODE_REGISTER, '1, '1, '0),
            open_row(hte_pkg::MODE_LOOK_ID, 16'd2, '0, '0),
            chk_row(hte_pkg::MODE_UNREG, 16'd1, '0, '0, 1'b1, 16'd1, '0, '0),
            chk_row(hte_pkg::MODE_UNREG, 16'd1, '0, '0, 1'b0, '0, '0, '0),
            chk_row(hte_pkg::MODE_LOOK_PAIR, '0, '0, '0, 1'b0, '0, '0, '0),
            chk_row(hte_pkg::MODE_UNREG, 16'd0, '0, '0, 1'b0, '0, '0, '0),
            chk_row(hte_pkg::MODE_LOOK_ID, 16'd0, '0, '0, 1'b0, '0, '0, '0),
            chk_row(MODE_SPARE_LO, 16'd3, 32'd3, 32'd3, 1'b0, '0, '0, '0),
            chk_row(MODE_SPARE_HI, '1, '1, '1, 1'b0, '0, '0, '0),
            open_row(hte_pkg::MODE_ATTACH, 16'h0011, 32'h0000_FFFF, 32'hFFFF_0000),
            open_row(hte_pkg::MODE_REGISTER, '0, '0, '0),
            open_row(hte_pkg::MODE_LOOK_ID, 16'h0011, '0, '0),
            open_row(hte_pkg::MODE_UNREG, 16'hFFFF, '0, '0)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) issue_cmd(rows[i].cmd, rows[i].fixed, rows[i].rsp);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_capacity(PHASE_CAP[ph]);
            idle_pct = (ph < PHASES / 3) ? 33 : (ph < 2 * PHASES / 3) ? 51 : 0;
            repeat (ITEMS_PER_PHASE) issue_cmd(random_cmd(), 1'b0, '0);
        end
        start <= 1'b0;
        @(posedge i_clk);

        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rsp_due.size() != 0) begin
            $display("%0d expected results never arrived", rsp_due.size());
            n_mismatch += rsp_due.size();
        end

        $display("Sent %0d commands (%0d directed) over %0d capacity settings, clamped too.",
                 n_sent, rows.size(), PHASES);
        $display("Checked %0d result beats; %0d failures.", n_checked, n_mismatch);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: handle_table_engine.f
sv/hte_pkg.sv
sv/hte_front.sv
sv/hte_queue.sv
sv/hte_back.sv
sv/handle_table_engine.sv
sim/tb.sv
